>>> sv/dbnms_pkg.sv
// Package for the detection box suppression block: sizes, register indexes,
// payload structs and the proposal entry type. No dependencies.
`default_nettype none
package dbnms_pkg;

	localparam int MAX_PROPOSALS = 1024;
	localparam int MAX_CLASSES   = 128;
	localparam int MAX_KEPT      = 64;

	localparam int CNT_W  = $clog2(MAX_PROPOSALS + 1);
	localparam int KEPT_W = $clog2(MAX_KEPT + 1);
	localparam int KIDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

	localparam logic [1:0] CFG_SCORE_THR   = 2'd0;
	localparam logic [1:0] CFG_OVERLAP_THR = 2'd1;
	localparam logic [1:0] CFG_MAX_DET     = 2'd2;

	localparam logic [16:0] SCORE_THR_RST   = 17'd16384;
	localparam logic [16:0] OVERLAP_THR_RST = 17'd29491;
	localparam logic [6:0]  MAX_DET_RST     = 7'd64;

	typedef struct packed {
		logic [16:0] center_x;
		logic [16:0] center_y;
		logic [16:0] box_width;
		logic [16:0] box_height;
		logic [16:0] cls_score;
		logic        last_class;
		logic        last_anchor;
	} in_item_t;

	typedef struct packed {
		logic [16:0] left;
		logic [16:0] top;
		logic [16:0] clip_width;
		logic [16:0] clip_height;
		logic [16:0] confidence;
		logic [6:0]  class_id;
		logic        empty_res;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [16:0] score;
		logic [6:0]  cls;
		logic [16:0] cx;
		logic [16:0] cy;
		logic [16:0] w;
		logic [16:0] h;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} chain_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_RD,
		ST_CMP,
		ST_WAIT,
		ST_ORD,
		ST_OCLIP,
		ST_OWAIT
	} state_t;

endpackage
`default_nettype wire

>>> sv/dbnms_cell.sv
// One cell of the sorted proposal chain: holds one entry, takes part in a
// parallel sorted insert or a shift toward the head. Uses dbnms_pkg.
`default_nettype none
module dbnms_cell import dbnms_pkg::*; (
	input  wire        clk,
	input  chain_ctl_t ctl,
	input  wire        valid,
	input  wire        prev_cond,
	input  entry_t     new_e,
	input  entry_t     prev_e,
	input  entry_t     next_e,
	output logic       cond,
	output entry_t     e
);

	entry_t e_q;

	assign e    = e_q;
	assign cond = !valid || (e_q.score < new_e.score);

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			e_q <= next_e;
		end else if (ctl.ins) begin
			if (prev_cond) begin
				e_q <= prev_e;
			end else if (cond) begin
				e_q <= new_e;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/dbnms_iou.sv
// Five-stage overlap test: inter*65536 > threshold*union on corner boxes
// in half units. Uses dbnms_pkg.
`default_nettype none
module dbnms_iou import dbnms_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  entry_t      a,
	input  entry_t      b,
	input  wire  [16:0] thr,
	output logic        done,
	output logic        sup
);

	function automatic logic signed [20:0] ext(input logic [16:0] x);
		ext = $signed({4'b0, x});
	endfunction

	function automatic logic [17:0] overlap(input logic [16:0] ac, input logic [16:0] as,
			input logic [16:0] bc, input logic [16:0] bs);
		logic signed [20:0] alo, ahi, blo, bhi, lo, hi, d;
		alo = (ext(ac) <<< 1) - ext(as);
		ahi = (ext(ac) <<< 1) + ext(as);
		blo = (ext(bc) <<< 1) - ext(bs);
		bhi = (ext(bc) <<< 1) + ext(bs);
		lo  = (alo > blo) ? alo : blo;
		hi  = (ahi < bhi) ? ahi : bhi;
		d   = hi - lo;
		overlap = (d < 0) ? 18'd0 : d[17:0];
	endfunction

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [17:0] iw_s1, ih_s1;
	logic [33:0] aa_s1, ab_s1;
	logic [35:0] inter_s2, inter_s3;
	logic [36:0] area_s2;
	logic [37:0] union_s3;
	logic [35:0] plo_s4, phi_s4;
	logic [51:0] inter_s4;
	logic        sup_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1    <= overlap(a.cx, a.w, b.cx, b.w);
		ih_s1    <= overlap(a.cy, a.h, b.cy, b.h);
		aa_s1    <= a.w * a.h;
		ab_s1    <= b.w * b.h;
		inter_s2 <= iw_s1 * ih_s1;
		area_s2  <= {1'b0, aa_s1, 2'b0} + {1'b0, ab_s1, 2'b0};
		inter_s3 <= inter_s2;
		union_s3 <= {1'b0, area_s2} - {2'b0, inter_s2};
		plo_s4   <= thr * union_s3[18:0];
		phi_s4   <= thr * union_s3[37:19];
		inter_s4 <= {inter_s3, 16'b0};
		sup_s5   <= {3'b0, inter_s4} > ({phi_s4, 19'b0} + {19'b0, plo_s4});
	end

	assign done = v_s5;
	assign sup  = sup_s5;

endmodule
`default_nettype wire

>>> sv/detection_box_nms_postprocess.sv
// Top level of the detection suppression block: best-class tracking,
// sorted proposal cell chain, kept-box RAM and output stage.
// Uses dbnms_pkg, dbnms_cell and dbnms_iou.
//
// Class scores are taken one per cycle while a frame streams in; the sorted
// insert of a proposal happens in the cycle that ends its anchor, across all
// cells of the chain at once. After the item that ends the frame the block
// stops taking input and runs suppression: while fewer boxes than the limit
// are kept, each proposal, head first, leaves the chain and is tested against
// the boxes kept so far, one kept box at a time through the single overlap
// pipeline and the kept-box RAM read port; it is kept unless one suppresses
// it. Each kept box is then read, clipped and held until out_ready; an empty
// frame gives one empty result. Input is taken again after the final result.
`default_nettype none
module detection_box_nms_postprocess import dbnms_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  wire         out_ready,
	output out_item_t   out_data,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [16:0] cfg_data
);

	typedef struct packed {
		logic [16:0] lo;
		logic [16:0] len;
	} clip_t;

	function automatic clip_t clip(input logic [16:0] c, input logic [16:0] s);
		logic signed [19:0] lo, hi, d;
		clip_t r;
		lo = ($signed({3'b0, c}) <<< 1) - $signed({3'b0, s});
		hi = ($signed({3'b0, c}) <<< 1) + $signed({3'b0, s});
		if (lo < 0) lo = 20'sd0;
		if (hi > 20'sd131072) hi = 20'sd131072;
		d = hi - lo;
		if (d < 0) d = 20'sd0;
		if (lo > 20'sd131072) lo = 20'sd131072;
		r.lo  = lo[17:1];
		r.len = d[17:1];
		clip = r;
	endfunction

	logic [16:0] score_thr_q, overlap_thr_q;
	logic [6:0]  max_det_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q   <= SCORE_THR_RST;
			overlap_thr_q <= OVERLAP_THR_RST;
			max_det_q     <= MAX_DET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCORE_THR:   score_thr_q   <= cfg_data;
				CFG_OVERLAP_THR: overlap_thr_q <= cfg_data;
				CFG_MAX_DET:     max_det_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [KEPT_W-1:0] nk_q, j_q, k_q;
	logic [6:0]       limit;
	logic             best_vld_q;
	logic [16:0]      best_q;
	logic [6:0]       best_cls_q, class_pos_q;
	entry_t           cand_q, kept_rd_q, new_e;
	out_item_t        out_q;
	logic             out_vld_q;
	clip_t            clip_x, clip_y;
	entry_t           kept_mem [MAX_KEPT];

	logic        acc, end_anchor, take, do_ins, pop, kept_we, kept_re, iou_start;
	logic        iou_done, iou_sup;
	logic [KIDX_W-1:0] kept_waddr, kept_raddr;
	logic [16:0] best_s;
	logic [6:0]  best_c;
	chain_ctl_t  ctl;

	assign limit      = (max_det_q < 7'(MAX_KEPT)) ? max_det_q : 7'(MAX_KEPT);
	assign in_ready   = (state_q == ST_IDLE);
	assign acc        = in_valid && in_ready;
	assign end_anchor = in_data.last_class || in_data.last_anchor;
	assign take       = !best_vld_q || (in_data.cls_score > best_q);
	assign best_s     = take ? in_data.cls_score : best_q;
	assign best_c     = take ? class_pos_q : best_cls_q;
	assign do_ins     = acc && end_anchor && (best_s > score_thr_q);
	assign ctl.ins    = do_ins;
	assign ctl.pop    = pop;

	always_comb begin
		new_e.score = best_s;
		new_e.cls   = best_c;
		new_e.cx    = in_data.center_x;
		new_e.cy    = in_data.center_y;
		new_e.w     = in_data.box_width;
		new_e.h     = in_data.box_height;
	end

	entry_t cell_e    [MAX_PROPOSALS];
	logic   cell_cond [MAX_PROPOSALS];

	for (genvar i = 0; i < MAX_PROPOSALS; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_cond;
		if (i == 0) begin : g_head
			assign prev_e    = new_e;
			assign prev_cond = 1'b0;
		end else begin : g_mid
			assign prev_e    = cell_e[i-1];
			assign prev_cond = cell_cond[i-1];
		end
		if (i == MAX_PROPOSALS - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_body
			assign next_e = cell_e[i+1];
		end
		dbnms_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.valid    (CNT_W'(i) < count_q),
			.prev_cond(prev_cond),
			.new_e    (new_e),
			.prev_e   (prev_e),
			.next_e   (next_e),
			.cond     (cell_cond[i]),
			.e        (cell_e[i])
		);
	end

	dbnms_iou u_iou (
		.clk   (clk),
		.arst_n(arst_n),
		.start (iou_start),
		.a     (cand_q),
		.b     (kept_rd_q),
		.thr   (overlap_thr_q),
		.done  (iou_done),
		.sup   (iou_sup)
	);

	assign kept_waddr = nk_q[KIDX_W-1:0];
	assign kept_raddr = (state_q == ST_ORD) ? k_q[KIDX_W-1:0] : j_q[KIDX_W-1:0];

	always_ff @(posedge clk) begin
		if (kept_we) kept_mem[kept_waddr] <= cand_q;
		if (kept_re) kept_rd_q <= kept_mem[kept_raddr];
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		kept_we   = 1'b0;
		kept_re   = 1'b0;
		iou_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc && in_data.last_anchor) state_d = ST_CAND;
			end
			ST_CAND: begin
				if (count_q != '0 && 7'(nk_q) < limit) begin
					pop     = 1'b1;
					state_d = ST_RD;
				end else if (nk_q == '0) begin
					state_d = ST_OCLIP;
				end else begin
					state_d = ST_ORD;
				end
			end
			ST_RD: begin
				if (j_q == nk_q) begin
					kept_we = 1'b1;
					state_d = ST_CAND;
				end else begin
					kept_re = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				iou_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (iou_done) state_d = iou_sup ? ST_CAND : ST_RD;
			end
			ST_ORD: begin
				kept_re = 1'b1;
				state_d = ST_OCLIP;
			end
			ST_OCLIP: begin
				state_d = ST_OWAIT;
			end
			ST_OWAIT: begin
				if (out_ready) begin
					if (nk_q == '0 || k_q + 1'b1 == nk_q) state_d = ST_IDLE;
					else state_d = ST_ORD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			nk_q        <= '0;
			j_q         <= '0;
			k_q         <= '0;
			best_vld_q  <= 1'b0;
			best_q      <= '0;
			best_cls_q  <= '0;
			class_pos_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				if (end_anchor) begin
					best_vld_q  <= 1'b0;
					best_q      <= '0;
					best_cls_q  <= '0;
					class_pos_q <= '0;
				end else begin
					best_vld_q <= 1'b1;
					best_q     <= best_s;
					best_cls_q <= best_c;
					if (class_pos_q < 7'(MAX_CLASSES - 1)) class_pos_q <= class_pos_q + 1'b1;
				end
				if (in_data.last_anchor) begin
					nk_q <= '0;
					k_q  <= '0;
				end
			end
			if (do_ins && count_q < CNT_W'(MAX_PROPOSALS)) count_q <= count_q + 1'b1;
			if (pop) begin
				count_q <= count_q - 1'b1;
				j_q     <= '0;
			end
			if (kept_we) nk_q <= nk_q + 1'b1;
			if (state_q == ST_WAIT && iou_done && !iou_sup) j_q <= j_q + 1'b1;
			if (state_q == ST_OCLIP) out_vld_q <= 1'b1;
			if (state_q == ST_OWAIT && out_ready) begin
				out_vld_q <= 1'b0;
				k_q       <= k_q + 1'b1;
				if (state_d == ST_IDLE) count_q <= '0;
			end
		end
	end

	always_comb begin
		clip_x = clip(kept_rd_q.cx, kept_rd_q.w);
		clip_y = clip(kept_rd_q.cy, kept_rd_q.h);
	end

	always_ff @(posedge clk) begin
		if (pop) cand_q <= cell_e[0];
		if (state_q == ST_OCLIP) begin
			if (nk_q == '0) begin
				out_q.left        <= '0;
				out_q.top         <= '0;
				out_q.clip_width  <= '0;
				out_q.clip_height <= '0;
				out_q.confidence  <= '0;
				out_q.class_id    <= '0;
				out_q.empty_res   <= 1'b1;
				out_q.last        <= 1'b1;
			end else begin
				out_q.left        <= clip_x.lo;
				out_q.clip_width  <= clip_x.len;
				out_q.top         <= clip_y.lo;
				out_q.clip_height <= clip_y.len;
				out_q.confidence  <= kept_rd_q.score;
				out_q.class_id    <= kept_rd_q.cls;
				out_q.empty_res   <= 1'b0;
				out_q.last        <= (k_q + 1'b1 == nk_q);
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while a result is pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PROPOSALS)) else $error("proposal count overflow");
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nk_q <= KEPT_W'(MAX_KEPT)) else $error("kept count overflow");
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last) |=> (count_q == '0 && in_ready))
		else $error("frame end did not clear the store");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for detection_box_nms_postprocess: streams class scores with anchor
// boxes, predicts the kept boxes per frame and checks every output transaction.
// Depends on dbnms_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench import dbnms_pkg::*; ();

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	detection_box_nms_postprocess dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	in_item_t pending_items[$];
	out_item_t expected_boxes[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_cycles = 0;
	int failures = 0;
	logic in_ready_seen = 1'b0;

	// predictor state
	logic [16:0] thr_score, thr_overlap;
	logic [6:0] det_limit;
	entry_t props[$];
	int best_sc;
	int best_cls, cls_pos;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint edge_lo(logic [16:0] c, logic [16:0] s);
		longint lo;
		lo = 2 * longint'(c) - longint'(s);
		return (lo < 0) ? 0 : lo;
	endfunction

	function automatic longint edge_hi(logic [16:0] c, logic [16:0] s);
		longint hi;
		hi = 2 * longint'(c) + longint'(s);
		return (hi > 131072) ? 131072 : hi;
	endfunction

	function automatic bit overlaps(entry_t a, entry_t b);
		longint acx, acy, aw, ah, bcx, bcy, bw, bh;
		longint iw, ih, inter4, union4;
		acx = longint'(a.cx); acy = longint'(a.cy);
		aw = longint'(a.w); ah = longint'(a.h);
		bcx = longint'(b.cx); bcy = longint'(b.cy);
		bw = longint'(b.w); bh = longint'(b.h);
		iw = ((2*acx+aw) < (2*bcx+bw) ? (2*acx+aw) : (2*bcx+bw))
			- ((2*acx-aw) > (2*bcx-bw) ? (2*acx-aw) : (2*bcx-bw));
		ih = ((2*acy+ah) < (2*bcy+bh) ? (2*acy+ah) : (2*bcy+bh))
			- ((2*acy-ah) > (2*bcy-bh) ? (2*acy-ah) : (2*bcy-bh));
		if (iw < 0) iw = 0;
		if (ih < 0) ih = 0;
		inter4 = iw * ih;
		union4 = 4*aw*ah + 4*bw*bh - inter4;
		return inter4 * 65536 > longint'(thr_overlap) * union4;
	endfunction

	task automatic predict_frame_boxes(in_item_t it);
		entry_t e, kept[$];
		out_item_t r;
		int pos, lim;
		bit keep;
		longint lo, hi;
		if (int'(it.cls_score) > best_sc) begin
			best_sc = it.cls_score;
			best_cls = cls_pos;
		end
		if (cls_pos < MAX_CLASSES - 1) cls_pos++;
		if (it.last_class || it.last_anchor) begin
			if (best_sc > int'(thr_score)) begin
				e.score = 17'(best_sc); e.cls = 7'(best_cls);
				e.cx = it.center_x; e.cy = it.center_y;
				e.w = it.box_width; e.h = it.box_height;
				pos = 0;
				while (pos < props.size() && props[pos].score >= e.score) pos++;
				if (pos < MAX_PROPOSALS) begin
					props.insert(pos, e);
					if (props.size() > MAX_PROPOSALS) void'(props.pop_back());
				end
			end
			best_sc = -1; best_cls = 0; cls_pos = 0;
		end
		if (!it.last_anchor) return;
		lim = (det_limit < MAX_KEPT) ? det_limit : MAX_KEPT;
		foreach (props[i]) begin
			if (kept.size() >= lim) break;
			keep = 1;
			foreach (kept[j]) if (overlaps(props[i], kept[j])) begin
				keep = 0;
				break;
			end
			if (keep) kept.insert(kept.size(), props[i]);
		end
		if (kept.size() == 0) begin
			r = '0; r.empty_res = 1; r.last = 1;
			expected_boxes.insert(expected_boxes.size(), r);
		end
		foreach (kept[k]) begin
			r = '0;
			lo = edge_lo(kept[k].cx, kept[k].w); hi = edge_hi(kept[k].cx, kept[k].w);
			r.left = 17'(((lo < 131072) ? lo : 131072) >> 1);
			r.clip_width = 17'(((hi - lo) < 0 ? 0 : hi - lo) >> 1);
			lo = edge_lo(kept[k].cy, kept[k].h); hi = edge_hi(kept[k].cy, kept[k].h);
			r.top = 17'(((lo < 131072) ? lo : 131072) >> 1);
			r.clip_height = 17'(((hi - lo) < 0 ? 0 : hi - lo) >> 1);
			r.confidence = kept[k].score;
			r.class_id = kept[k].cls;
			r.last = (k == kept.size() - 1);
			expected_boxes.insert(expected_boxes.size(), r);
		end
		props.delete();
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_seen) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles <= hold_off_cycles - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		in_ready_seen <= in_valid && in_ready;
		if (in_valid && in_ready) predict_frame_boxes(in_data);
		if (out_valid && out_ready) begin
			if (expected_boxes.size() == 0) begin
				$display("%t unexpected result %p", $realtime, out_data);
				failures++;
			end else begin
				out_item_t x;
				x = expected_boxes.pop_front();
				if (x !== out_data) begin
					$display("%t mismatch expected %p actual %p", $realtime, x, out_data);
					failures++;
				end
			end
		end
	end

	function automatic in_item_t make_item(bit lc, bit la, logic [16:0] sc);
		in_item_t it;
		it.center_x = 17'($urandom_range(65536));
		it.center_y = 17'($urandom_range(65536));
		it.box_width = 17'($urandom_range(65536));
		it.box_height = 17'($urandom_range(65536));
		if ($urandom_range(3) == 0) begin
			it.box_width = 17'($urandom_range(8192));
			it.box_height = 17'($urandom_range(8192));
		end
		it.cls_score = sc;
		it.last_class = lc;
		it.last_anchor = la;
		return it;
	endfunction

	task automatic add_frame(int anchors, int max_cls);
		int nc;
		for (int a = 0; a < anchors; a++) begin
			nc = $urandom_range(max_cls, 1);
			for (int c = 0; c < nc; c++)
				pending_items.insert(pending_items.size(), make_item(c == nc - 1,
					(a == anchors - 1) && (c == nc - 1), 17'($urandom_range(65536))));
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SCORE_THR: thr_score = val;
			CFG_OVERLAP_THR: thr_overlap = val[16:0];
			CFG_MAX_DET: det_limit = val[6:0];
			default: ;
		endcase
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		while ((pending_items.size() > 0 || in_valid || expected_boxes.size() > 0)
			&& guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	initial begin
		in_item_t it;
		thr_score = SCORE_THR_RST; thr_overlap = OVERLAP_THR_RST; det_limit = MAX_DET_RST;
		best_sc = -1; best_cls = 0; cls_pos = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes, mid-anchor frame end, empty frame, equal scores
		it = '0; it.last_anchor = 1; pending_items.insert(pending_items.size(), it);
		it = '1; it.center_x = 65536; it.center_y = 65536; it.box_width = 65536;
		it.box_height = 65536; it.cls_score = 65536; it.last_anchor = 0;
		pending_items.insert(pending_items.size(), it);
		it.center_x = 0; it.center_y = 0; it.cls_score = 65535; it.last_class = 0;
		pending_items.insert(pending_items.size(), it);
		it.center_x = 1000; it.center_y = 1000; it.last_anchor = 1;
		pending_items.insert(pending_items.size(), it);
		pending_items.insert(pending_items.size(), make_item(1, 0, 17'd40000));
		pending_items.insert(pending_items.size(), make_item(1, 0, 17'd40000));
		pending_items.insert(pending_items.size(), make_item(0, 1, 17'd50000));
		drain();

		write_reg(CFG_SCORE_THR, 17'd0);
		write_reg(CFG_OVERLAP_THR, 17'd0);
		write_reg(CFG_MAX_DET, 17'd0);
		write_reg(CFG_UNUSED, 17'd5);
		add_frame(4, 3);
		drain();
		write_reg(CFG_MAX_DET, 17'd1);
		write_reg(CFG_OVERLAP_THR, 17'd65536);
		add_frame(6, 2);
		drain();
		write_reg(CFG_MAX_DET, 17'd127);
		write_reg(CFG_SCORE_THR, 17'd65536);
		add_frame(3, 2);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 50 : 0;
			recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 30 : 0;
			write_reg(CFG_SCORE_THR, 17'($urandom_range(30000)));
			write_reg(CFG_OVERLAP_THR, 17'($urandom_range(65536)));
			write_reg(CFG_MAX_DET, 17'($urandom_range(70)));
			if (ph == 1) hold_off_cycles = 400;
			for (int f = 0; f < 3; f++) add_frame($urandom_range(8, 1), 2);
			if (ph == 2) add_frame(16, 1);
			drain();
		end

		if (failures == 0 && expected_boxes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

>>> filelist.f
sv/dbnms_pkg.sv
sv/dbnms_cell.sv
sv/dbnms_iou.sv
sv/detection_box_nms_postprocess.sv
tb/testbench.sv
